// ===== rtl/csfla_pkg.sv =====
// Shared types, constants and the control program of the slot allocator.
// Depends on nothing; the other files but csfla_ram refer to it by scoped names.
package csfla_pkg;

  // Field widths and fixed codes
  localparam int SLOTS_DEF  = 1024;
  localparam int PTR_W      = 64;
  localparam int LINK_W     = 11;
  localparam int BYTES_W    = 32;
  localparam int OUT_SLOT_W = 10;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam logic [LINK_W-1:0] END_MARK = '1;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REGION = 2'd3;

  // Datapath actions
  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RD_FH  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GROW   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RD_CUR = 3'd5;
  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd6;

  // Jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] COND_NEVER    = 4'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] COND_DISPATCH = 4'd2;
  localparam logic [COND_W-1:0] COND_CLR_MORE = 4'd3;
  localparam logic [COND_W-1:0] COND_FH_EMPTY = 4'd4;
  localparam logic [COND_W-1:0] COND_HM_FULL  = 4'd5;
  localparam logic [COND_W-1:0] COND_CUR_BAD  = 4'd6;
  localparam logic [COND_W-1:0] COND_CUR_END  = 4'd7;
  localparam logic [COND_W-1:0] COND_WALK_BAD = 4'd8;
  localparam logic [COND_W-1:0] COND_OUTSIDE  = 4'd9;

  // Result slot source
  localparam int SSEL_W = 2;
  localparam logic [SSEL_W-1:0] SLOT_ZERO = 2'd0;
  localparam logic [SSEL_W-1:0] SLOT_FH   = 2'd1;
  localparam logic [SSEL_W-1:0] SLOT_HM   = 2'd2;

  // Program steps
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] STEP_CLR     = 4'd0;
  localparam logic [UPC_W-1:0] STEP_IDLE    = 4'd1;
  localparam logic [UPC_W-1:0] STEP_A_RDFH  = 4'd2;
  localparam logic [UPC_W-1:0] STEP_A_POP   = 4'd3;
  localparam logic [UPC_W-1:0] STEP_A_CHKHM = 4'd4;
  localparam logic [UPC_W-1:0] STEP_A_GROW  = 4'd5;
  localparam logic [UPC_W-1:0] STEP_A_FULL  = 4'd6;
  localparam logic [UPC_W-1:0] STEP_R_RD    = 4'd7;
  localparam logic [UPC_W-1:0] STEP_R_OUT   = 4'd8;
  localparam logic [UPC_W-1:0] STEP_E_RANGE = 4'd9;
  localparam logic [UPC_W-1:0] STEP_F_END   = 4'd10;
  localparam logic [UPC_W-1:0] STEP_F_RD    = 4'd11;
  localparam logic [UPC_W-1:0] STEP_F_CHK   = 4'd12;
  localparam logic [UPC_W-1:0] STEP_F_PUSH  = 4'd13;
  localparam logic [UPC_W-1:0] STEP_E_OK    = 4'd14;
  localparam logic [UPC_W-1:0] STEP_E_REG   = 4'd15;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PTR_W-1:0]   code_pointer;
    logic [LINK_W-1:0]  link;
    logic [LINK_W-1:0]  index;
    logic [PTR_W-1:0]   region_base;
    logic [BYTES_W-1:0] region_bytes;
  } in_item_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic [PTR_W-1:0]      pointer;
    logic [STATUS_W-1:0]   status;
  } out_item_t;

  // One control word per program step
  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [COND_W-1:0]   cond;
    logic [UPC_W-1:0]    tgt;
    logic                emit;
    logic [STATUS_W-1:0] status;
    logic [SSEL_W-1:0]   slot_sel;
    logic                ptr_sel;
  } ctrl_t;

  // Datapath flags tested by the sequencer
  typedef struct packed {
    logic clr_more;
    logic fh_empty;
    logic hm_full;
    logic cur_bad;
    logic cur_end;
    logic walk_bad;
    logic outside;
  } flags_t;

  function automatic ctrl_t cw(input logic [ACT_W-1:0] act, input logic [COND_W-1:0] cond,
                               input logic [UPC_W-1:0] tgt, input logic emit,
                               input logic [STATUS_W-1:0] status,
                               input logic [SSEL_W-1:0] slot_sel, input logic ptr_sel);
    ctrl_t w;
    w.act      = act;
    w.cond     = cond;
    w.tgt      = tgt;
    w.emit     = emit;
    w.status   = status;
    w.slot_sel = slot_sel;
    w.ptr_sel  = ptr_sel;
    return w;
  endfunction

  // Control store
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] step);
    ctrl_t w;
    case (step)
      STEP_CLR:     w = cw(ACT_CLEAR,  COND_CLR_MORE, STEP_CLR,     1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_IDLE:    w = cw(ACT_NONE,   COND_DISPATCH, STEP_IDLE,    1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_A_RDFH:  w = cw(ACT_RD_FH,  COND_FH_EMPTY, STEP_A_CHKHM, 1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_A_POP:   w = cw(ACT_POP,    COND_ALWAYS,   STEP_IDLE,    1'b1, ST_OK,     SLOT_FH,   1'b0);
      STEP_A_CHKHM: w = cw(ACT_NONE,   COND_HM_FULL,  STEP_A_FULL,  1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_A_GROW:  w = cw(ACT_GROW,   COND_ALWAYS,   STEP_IDLE,    1'b1, ST_OK,     SLOT_HM,   1'b0);
      STEP_A_FULL:  w = cw(ACT_NONE,   COND_ALWAYS,   STEP_IDLE,    1'b1, ST_FULL,   SLOT_ZERO, 1'b0);
      STEP_R_RD:    w = cw(ACT_RD_CUR, COND_CUR_BAD,  STEP_E_RANGE, 1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_R_OUT:   w = cw(ACT_NONE,   COND_ALWAYS,   STEP_IDLE,    1'b1, ST_OK,     SLOT_ZERO, 1'b1);
      STEP_E_RANGE: w = cw(ACT_NONE,   COND_ALWAYS,   STEP_IDLE,    1'b1, ST_RANGE,  SLOT_ZERO, 1'b0);
      STEP_F_END:   w = cw(ACT_NONE,   COND_CUR_END,  STEP_E_OK,    1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_F_RD:    w = cw(ACT_RD_CUR, COND_WALK_BAD, STEP_E_RANGE, 1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_F_CHK:   w = cw(ACT_NONE,   COND_OUTSIDE,  STEP_E_REG,   1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_F_PUSH:  w = cw(ACT_PUSH,   COND_ALWAYS,   STEP_F_END,   1'b0, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_E_OK:    w = cw(ACT_NONE,   COND_ALWAYS,   STEP_IDLE,    1'b1, ST_OK,     SLOT_ZERO, 1'b0);
      STEP_E_REG:   w = cw(ACT_NONE,   COND_ALWAYS,   STEP_IDLE,    1'b1, ST_REGION, SLOT_ZERO, 1'b0);
      default:      w = cw(ACT_NONE,   COND_ALWAYS,   STEP_IDLE,    1'b0, ST_OK,     SLOT_ZERO, 1'b0);
    endcase
    return w;
  endfunction

  // Entry step for each mode; the unused mode answers all zero
  function automatic logic [UPC_W-1:0] entry(input logic [MODE_W-1:0] mode);
    logic [UPC_W-1:0] s;
    case (mode)
      MODE_ALLOC: s = STEP_A_RDFH;
      MODE_READ:  s = STEP_R_RD;
      MODE_FREE:  s = STEP_F_END;
      default:    s = STEP_E_OK;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/catch_slot_free_list_allocator.sv =====
// Top level of the slot allocator: sequencer plus datapath.
// Depends on csfla_pkg, csfla_seq and csfla_dp, and on csfla_ram through csfla_dp.
//
// Usage: after reset the block sweeps both slot stores to zero, one slot
// per cycle, with busy high. An item transfers when start is high and
// busy is low; busy then stays high until the item is done.
// Each item gives exactly one result, shown on out_item for one cycle with
// out_strobe high; the receiver cannot stall it, so sample it when strobed.
// Each step is one control word. Allocating reads the free-list head and
// pops it or, if the list is empty, grows the table or reports full; a
// read reads the store and answers. Every slot of a freed chain costs one
// store read, a region compare and one store write, each in a step of its
// own, so the chain walk sets the worst-case time.
module catch_slot_free_list_allocator #(
  parameter int SLOTS = csfla_pkg::SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  csfla_pkg::in_item_t   in_item,
  output logic                  out_strobe,
  output csfla_pkg::out_item_t  out_item
);

  csfla_pkg::ctrl_t  ctrl;
  csfla_pkg::flags_t flags;
  logic              accept;

  assign accept = start && !busy;

  csfla_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  csfla_dp #(.SLOTS(SLOTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .accept     (accept),
    .in_item    (in_item),
    .flags      (flags),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== rtl/csfla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module csfla_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/csfla_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on csfla_pkg for the program, codes and control types.
module csfla_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [csfla_pkg::MODE_W-1:0]  mode,
  input  csfla_pkg::flags_t             flags,
  output csfla_pkg::ctrl_t              ctrl,
  output logic                          busy
);

  logic [csfla_pkg::UPC_W-1:0] upc_r;
  logic [csfla_pkg::UPC_W-1:0] upc_nxt;
  logic                        taken;

  assign ctrl = csfla_pkg::ucode(upc_r);
  assign busy = (upc_r != csfla_pkg::STEP_IDLE);

  // Evaluate the jump condition of the current word
  always_comb begin
    case (ctrl.cond)
      csfla_pkg::COND_NEVER:    taken = 1'b0;
      csfla_pkg::COND_ALWAYS:   taken = 1'b1;
      csfla_pkg::COND_DISPATCH: taken = 1'b0;
      csfla_pkg::COND_CLR_MORE: taken = flags.clr_more;
      csfla_pkg::COND_FH_EMPTY: taken = flags.fh_empty;
      csfla_pkg::COND_HM_FULL:  taken = flags.hm_full;
      csfla_pkg::COND_CUR_BAD:  taken = flags.cur_bad;
      csfla_pkg::COND_CUR_END:  taken = flags.cur_end;
      csfla_pkg::COND_WALK_BAD: taken = flags.walk_bad;
      csfla_pkg::COND_OUTSIDE:  taken = flags.outside;
      default:                  taken = 1'b0;
    endcase
  end

  // Pick the next step: dispatch on a start, jump, or advance
  always_comb begin
    if (ctrl.cond == csfla_pkg::COND_DISPATCH) begin
      upc_nxt = start ? csfla_pkg::entry(mode) : upc_r;
    end else if (taken) begin
      upc_nxt = ctrl.tgt;
    end else begin
      upc_nxt = upc_r + csfla_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= csfla_pkg::STEP_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // A result step always returns to idle
  a_emit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> upc_r == csfla_pkg::STEP_IDLE)
    else $error("sequencer did not return to idle after a result");

  // A transfer in starts work at once
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

endmodule

// ===== rtl/csfla_dp.sv =====
// Datapath: slot stores, list registers, region check and result register.
// Depends on csfla_pkg and csfla_ram.
module csfla_dp #(
  parameter int SLOTS = csfla_pkg::SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csfla_pkg::ctrl_t       ctrl,
  input  logic                   accept,
  input  csfla_pkg::in_item_t    in_item,
  output csfla_pkg::flags_t      flags,
  output logic                   out_strobe,
  output csfla_pkg::out_item_t   out_item
);

  localparam int AW = $clog2(SLOTS);
  localparam int SW = $clog2(SLOTS + 1);
  localparam logic [csfla_pkg::LINK_W-1:0] SLOTS_L = csfla_pkg::LINK_W'(SLOTS);

  // List state
  logic [csfla_pkg::LINK_W-1:0] free_head_r, free_head_nxt;
  logic [csfla_pkg::LINK_W-1:0] hm_r, hm_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;

  // Item registers
  logic [csfla_pkg::PTR_W-1:0]   ptr_in_r;
  logic [csfla_pkg::LINK_W-1:0]  link_in_r;
  logic [csfla_pkg::LINK_W-1:0]  cur_r, cur_nxt;
  logic [SW-1:0]                 steps_r, steps_nxt;
  logic [csfla_pkg::PTR_W-1:0]   base_r;
  logic [csfla_pkg::BYTES_W-1:0] bytes_r;

  // Store ports
  logic                         we, re;
  logic [AW-1:0]                waddr, raddr;
  logic [csfla_pkg::PTR_W-1:0]  wptr, rd_ptr;
  logic [csfla_pkg::LINK_W-1:0] wlink, rd_link;
  logic [csfla_pkg::PTR_W-1:0]  diff;

  logic                  out_strobe_r;
  csfla_pkg::out_item_t  out_item_r;
  csfla_pkg::out_item_t  out_item_nxt;

  csfla_ram #(.W(csfla_pkg::PTR_W), .DEPTH(SLOTS)) u_ptr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wptr),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_ptr)
  );

  csfla_ram #(.W(csfla_pkg::LINK_W), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wlink),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_link)
  );

  // Store access per action
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cur_r[AW-1:0];
    raddr = cur_r[AW-1:0];
    wptr  = ptr_in_r;
    wlink = link_in_r;
    case (ctrl.act)
      csfla_pkg::ACT_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wptr  = '0;
        wlink = '0;
      end
      csfla_pkg::ACT_RD_FH: begin
        re    = 1'b1;
        raddr = free_head_r[AW-1:0];
      end
      csfla_pkg::ACT_POP: begin
        we    = 1'b1;
        waddr = free_head_r[AW-1:0];
      end
      csfla_pkg::ACT_GROW: begin
        we    = 1'b1;
        waddr = hm_r[AW-1:0];
      end
      csfla_pkg::ACT_RD_CUR: begin
        re = 1'b1;
      end
      csfla_pkg::ACT_PUSH: begin
        we    = 1'b1;
        wptr  = '0;
        wlink = free_head_r;
      end
      default: ;
    endcase
  end

  // List and walk register updates
  always_comb begin
    free_head_nxt = free_head_r;
    hm_nxt        = hm_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    case (ctrl.act)
      csfla_pkg::ACT_CLEAR: clr_cnt_nxt = clr_cnt_r + AW'(1);
      csfla_pkg::ACT_POP:   free_head_nxt = rd_link;
      csfla_pkg::ACT_GROW:  hm_nxt = hm_r + csfla_pkg::LINK_W'(1);
      csfla_pkg::ACT_PUSH: begin
        free_head_nxt = cur_r;
        cur_nxt       = rd_link;
        steps_nxt     = steps_r + SW'(1);
      end
      default: ;
    endcase
    if (accept) begin
      cur_nxt   = in_item.index;
      steps_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= csfla_pkg::END_MARK;
      hm_r        <= '0;
      clr_cnt_r   <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      hm_r        <= hm_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  // Walk position and captured item fields
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    if (accept) begin
      ptr_in_r  <= in_item.code_pointer;
      link_in_r <= in_item.link;
      base_r    <= in_item.region_base;
      bytes_r   <= in_item.region_bytes;
    end
  end

  // Flags for the sequencer; region test is unsigned with wraparound
  assign diff = rd_ptr - base_r;
  always_comb begin
    flags.clr_more = (clr_cnt_r != AW'(SLOTS - 1));
    flags.fh_empty = (free_head_r >= SLOTS_L);
    flags.hm_full  = (hm_r >= SLOTS_L);
    flags.cur_bad  = (cur_r >= SLOTS_L);
    flags.cur_end  = (cur_r == csfla_pkg::END_MARK);
    flags.walk_bad = (steps_r >= SW'(SLOTS)) || (cur_r >= SLOTS_L);
    flags.outside  = (diff >= {{(csfla_pkg::PTR_W - csfla_pkg::BYTES_W){1'b0}}, bytes_r});
  end

  // Build the result
  always_comb begin
    out_item_nxt.status  = ctrl.status;
    out_item_nxt.pointer = ctrl.ptr_sel ? rd_ptr : '0;
    case (ctrl.slot_sel)
      csfla_pkg::SLOT_FH: out_item_nxt.slot = free_head_r[csfla_pkg::OUT_SLOT_W-1:0];
      csfla_pkg::SLOT_HM: out_item_nxt.slot = hm_r[csfla_pkg::OUT_SLOT_W-1:0];
      default:            out_item_nxt.slot = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // The high mark never passes the table size
  a_hm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hm_r <= SLOTS_L)
    else $error("high mark beyond table size");

  // Growing the table moves the high mark by one
  a_grow_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.act == csfla_pkg::ACT_GROW |=> hm_r == $past(hm_r) + csfla_pkg::LINK_W'(1))
    else $error("high mark did not advance on grow");

  // A pushed slot leaves a valid list head
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.act == csfla_pkg::ACT_PUSH |=> free_head_r < SLOTS_L)
    else $error("free list head invalid after push");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for catch_slot_free_list_allocator: directed corner cases, chain
// building and freeing, a table-fill pass and random traffic, scored against a shadow table.
// Depends on csfla_pkg and the allocator top level only.
module tb;

  localparam int NSLOT      = csfla_pkg::SLOTS_DEF;
  localparam int PTR_W      = csfla_pkg::PTR_W;
  localparam int LINK_W     = csfla_pkg::LINK_W;
  localparam int BYTES_W    = csfla_pkg::BYTES_W;
  localparam int MODE_W     = csfla_pkg::MODE_W;
  localparam int OUT_SLOT_W = csfla_pkg::OUT_SLOT_W;
  localparam logic [LINK_W-1:0] END_MARK   = csfla_pkg::END_MARK;
  localparam logic [MODE_W-1:0] MODE_ALLOC = csfla_pkg::MODE_ALLOC;
  localparam logic [MODE_W-1:0] MODE_READ  = csfla_pkg::MODE_READ;
  localparam logic [MODE_W-1:0] MODE_FREE  = csfla_pkg::MODE_FREE;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;
  localparam logic [csfla_pkg::STATUS_W-1:0] ST_FULL   = csfla_pkg::ST_FULL;
  localparam logic [csfla_pkg::STATUS_W-1:0] ST_RANGE  = csfla_pkg::ST_RANGE;
  localparam logic [csfla_pkg::STATUS_W-1:0] ST_REGION = csfla_pkg::ST_REGION;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  csfla_pkg::in_item_t  in_item = '0;
  logic                 out_strobe;
  csfla_pkg::out_item_t out_item;

  catch_slot_free_list_allocator #(.SLOTS(NSLOT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Shadow slot table
  logic [PTR_W-1:0]  ptr_mem  [NSLOT];
  logic [LINK_W-1:0] link_mem [NSLOT];
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] fresh_mark;

  csfla_pkg::in_item_t  cmd_q[$];   // commands waiting for the driver
  csfla_pkg::out_item_t due_q[$];   // results owed by the block, oldest first

  int launched = 0;
  int taken = 0;
  int issued = 0;
  int checked = 0;
  int mismatches = 0;
  int idle_left = 0;
  bit steady = 1'b0;
  int n_alloc = 0;
  int n_read = 0;
  int n_free = 0;
  int n_full = 0;
  int n_range = 0;
  int n_region = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one command to the shadow table and return the result it owes
  function automatic csfla_pkg::out_item_t table_op(input csfla_pkg::in_item_t c);
    csfla_pkg::out_item_t r;
    logic [LINK_W-1:0]    s;
    logic [LINK_W-1:0]    cur;
    logic [LINK_W-1:0]    nxt;
    int                   steps;
    bit                   stop;
    r = '0;
    s = END_MARK;
    case (c.mode)
      MODE_ALLOC: begin
        n_alloc++;
        if (free_head < NSLOT) begin
          s = free_head;
          free_head = link_mem[s];
        end else if (fresh_mark < NSLOT) begin
          s = fresh_mark;
          fresh_mark = fresh_mark + 1'b1;
        end
        if (s == END_MARK) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          ptr_mem[s] = c.code_pointer;
          link_mem[s] = c.link;
          r.slot = s[OUT_SLOT_W-1:0];
        end
      end
      MODE_READ: begin
        n_read++;
        if (c.index < NSLOT) begin
          r.pointer = ptr_mem[c.index];
        end else begin
          r.status = ST_RANGE;
          n_range++;
        end
      end
      MODE_FREE: begin
        n_free++;
        cur = c.index;
        steps = 0;
        stop = 1'b0;
        // walk the chain, pushing each slot onto the free list until its end or an error
        while (!stop && cur != END_MARK) begin
          if (steps >= NSLOT || cur >= NSLOT) begin
            r.status = ST_RANGE;
            n_range++;
            stop = 1'b1;
          end else if ((ptr_mem[cur] - c.region_base) >= PTR_W'(c.region_bytes)) begin
            r.status = ST_REGION;
            n_region++;
            stop = 1'b1;
          end else begin
            ptr_mem[cur] = '0;
            nxt = link_mem[cur];
            link_mem[cur] = free_head;
            free_head = cur;
            cur = nxt;
            steps++;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [PTR_W-1:0] got,
                               input logic [PTR_W-1:0] want);
    mismatches++;
    $display("%0t ns: result %0d %s: got %0h, expected %0h", $time, checked, what, got, want);
  endtask

  // Score strobed results, then log a new transfer and its expected result
  always @(posedge clk) begin : monitor
    csfla_pkg::out_item_t want;
    if (rst_n) begin
      if (out_strobe) begin
        checked++;
        if (due_q.size() == 0) begin
          note_mismatch("arrived with nothing due, status", PTR_W'(out_item.status), '0);
        end else begin
          want = due_q.pop_front();
          if (out_item.slot !== want.slot)
            note_mismatch("slot", PTR_W'(out_item.slot), PTR_W'(want.slot));
          if (out_item.pointer !== want.pointer)
            note_mismatch("pointer", out_item.pointer, want.pointer);
          if (out_item.status !== want.status)
            note_mismatch("status", PTR_W'(out_item.status), PTR_W'(want.status));
        end
      end
      if (start && !busy) begin
        taken++;
        due_q.push_back(table_op(in_item));
      end
    end
  end

  // Offer commands from the queue, with random idle gaps after each transfer
  always @(negedge clk) begin : driver
    int roll;
    if (rst_n) begin
      if (start && launched != taken) begin
        // hold the offer until the block takes it
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_item <= cmd_q.pop_front();
        start <= 1'b1;
        launched++;
        roll = $urandom_range(0, 99);
        if (steady || roll < 45)
          idle_left = 0;
        else if (roll < 85)
          idle_left = $urandom_range(1, 3);
        else if (roll < 97)
          idle_left = $urandom_range(4, 12);
        else
          idle_left = $urandom_range(20, 60);
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic [PTR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic post(input logic [MODE_W-1:0] mode, input logic [PTR_W-1:0] ptr,
                      input logic [LINK_W-1:0] lnk, input logic [LINK_W-1:0] idx,
                      input logic [PTR_W-1:0] base, input logic [BYTES_W-1:0] bytes);
    csfla_pkg::in_item_t c;
    c.mode = mode;
    c.code_pointer = ptr;
    c.link = lnk;
    c.index = idx;
    c.region_base = base;
    c.region_bytes = bytes;
    cmd_q.push_back(c);
    issued++;
  endtask

  // Wait until every queued command has transferred and every result is back
  task automatic settle();
    do @(negedge clk);
    while (cmd_q.size() != 0 || launched != taken || due_q.size() != 0);
    @(posedge clk);
  endtask

  // Guess which slot the next allocate gets, advancing the local copies
  function automatic logic [LINK_W-1:0] guess_grant(inout logic [LINK_W-1:0] fh,
                                                    inout logic [LINK_W-1:0] hm);
    logic [LINK_W-1:0] s;
    s = END_MARK;
    if (fh < NSLOT) begin
      s = fh;
      fh = link_mem[fh];
    end else if (hm < NSLOT) begin
      s = hm;
      hm = hm + 1'b1;
    end
    return s;
  endfunction

  // Build one linked chain inside a region, read random members back, and mostly free it
  task automatic chain_burst();
    logic [LINK_W-1:0]  fh;
    logic [LINK_W-1:0]  hm;
    logic [LINK_W-1:0]  s;
    logic [LINK_W-1:0]  prev;
    logic [LINK_W-1:0]  head;
    logic [LINK_W-1:0]  members[$];
    logic [PTR_W-1:0]   base;
    logic [BYTES_W-1:0] bytes;
    logic [BYTES_W-1:0] off;
    logic [BYTES_W-1:0] span;
    int                 n;
    int                 pick;
    settle();
    steady = ($urandom_range(0, 3) == 0);
    fh = free_head;
    hm = fresh_mark;
    prev = END_MARK;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 3))
      0: base = rand64();
      1: base = '1 - PTR_W'($urandom_range(0, 4095));
      2: base = PTR_W'($urandom_range(0, 4095));
      default: base = {$urandom, 32'h0};
    endcase
    case ($urandom_range(0, 3))
      0: bytes = $urandom_range(1, 64);
      1: bytes = '1;
      default: bytes = $urandom | 32'h1;
    endcase
    for (int k = 0; k < n; k++) begin
      s = guess_grant(fh, hm);
      case ($urandom_range(0, 7))
        0: off = '0;
        1: off = bytes - 1'b1;
        default: off = $urandom_range(0, bytes - 1'b1);
      endcase
      post(MODE_ALLOC, base + PTR_W'(off), prev, LINK_W'($urandom), rand64(), $urandom);
      if (s != END_MARK) begin
        members.push_back(s);
        prev = s;
      end
      if (members.size() > 0 && $urandom_range(0, 4) == 0)
        post(MODE_READ, rand64(), LINK_W'($urandom),
             members[$urandom_range(0, members.size() - 1)], rand64(), $urandom);
    end
    if (members.size() == 0 || $urandom_range(0, 4) == 0)
      return;
    // free from the newest slot; now and then from a random member or with a tighter region
    pick = $urandom_range(0, 9);
    head = (pick == 0) ? members[$urandom_range(0, members.size() - 1)] : prev;
    span = (pick == 1 || pick == 2) ? BYTES_W'($urandom_range(0, bytes)) : bytes;
    post(MODE_FREE, rand64(), LINK_W'($urandom), head, base, span);
    if ($urandom_range(0, 2) == 0)
      post(MODE_READ, rand64(), LINK_W'($urandom), head, rand64(), $urandom);
  endtask

  // Loose commands of every mode with arbitrary links and indexes
  task automatic noise_burst();
    logic [LINK_W-1:0]  lnk;
    logic [LINK_W-1:0]  idx;
    logic [PTR_W-1:0]   base;
    logic [BYTES_W-1:0] bytes;
    int                 n;
    steady = ($urandom_range(0, 3) == 0);
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: lnk = END_MARK;
        1: lnk = LINK_W'($urandom_range(0, fresh_mark));
        2: lnk = LINK_W'($urandom);
        default: lnk = LINK_W'($urandom_range(NSLOT, END_MARK - 1));
      endcase
      case ($urandom_range(0, 4))
        0: idx = END_MARK;
        1, 2: idx = LINK_W'($urandom_range(0, fresh_mark));
        3: idx = LINK_W'($urandom);
        default: idx = LINK_W'($urandom_range(NSLOT, END_MARK - 1));
      endcase
      case ($urandom_range(0, 2))
        0: begin
          base = '0;
          bytes = '1;
        end
        1: begin
          base = rand64();
          bytes = $urandom;
        end
        default: begin
          base = rand64();
          bytes = '0;
        end
      endcase
      post(MODE_W'($urandom_range(0, 3)), rand64(), lnk, idx, base, bytes);
    end
  endtask

  initial begin : stimulus
    logic [LINK_W-1:0] h;
    logic [LINK_W-1:0] fh;
    logic [LINK_W-1:0] hm;
    logic [LINK_W-1:0] s;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] heads[$];
    int                full_mark;
    int                guard;
    for (int i = 0; i < NSLOT; i++) begin
      ptr_mem[i] = '0;
      link_mem[i] = '0;
    end
    free_head = END_MARK;
    fresh_mark = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads of a clean table, out-of-range reads, the unused mode
    post(MODE_READ, '0, '0, '0, '0, '0);
    post(MODE_READ, '0, '0, END_MARK, '0, '0);
    post(MODE_READ, '0, '0, LINK_W'(NSLOT), '0, '0);
    post(MODE_NOP, '1, '1, '1, '1, '1);
    // two slots linked, then a walk that stops on a pointer outside the region
    post(MODE_ALLOC, '1, END_MARK, '0, '0, '0);
    post(MODE_ALLOC, '0, '0, '1, '1, '1);
    post(MODE_READ, '0, '0, '0, '0, '0);
    post(MODE_FREE, '0, '0, LINK_W'(1), '0, '1);
    post(MODE_FREE, '0, '0, END_MARK, '0, '0);
    post(MODE_FREE, '0, '0, LINK_W'(1500), '0, '1);
    // a chain whose link runs past the table
    post(MODE_ALLOC, PTR_W'(64'h1234), LINK_W'(1500), '0, '0, '0);
    post(MODE_FREE, '0, '0, LINK_W'(1), '0, '1);
    // region edges: top of address space, empty region, wrap, both bounds
    post(MODE_FREE, '0, '0, '0, '1, BYTES_W'(1));
    post(MODE_ALLOC, PTR_W'(8), END_MARK, '0, '0, '0);
    post(MODE_FREE, '0, '0, '0, '0, '0);
    post(MODE_FREE, '0, '0, '0, '1 - PTR_W'(15), BYTES_W'(32));
    post(MODE_ALLOC, PTR_W'(100), END_MARK, '0, '0, '0);
    post(MODE_FREE, '0, '0, '0, PTR_W'(101), '1);
    post(MODE_FREE, '0, '0, '0, PTR_W'(1), BYTES_W'(99));
    post(MODE_FREE, '0, '0, '0, PTR_W'(1), BYTES_W'(100));

    // Empty the free list, then build a two-slot loop and free it twice
    settle();
    guard = 0;
    while (free_head != END_MARK && guard < 8) begin
      post(MODE_ALLOC, PTR_W'(guard), END_MARK, '0, '0, '0);
      settle();
      guard++;
    end
    h = fresh_mark;
    post(MODE_ALLOC, PTR_W'(5), h + 1'b1, '0, '0, '0);
    post(MODE_ALLOC, PTR_W'(6), h, '0, '0, '0);
    post(MODE_FREE, '0, '0, h + 1'b1, '0, '1);
    post(MODE_FREE, '0, '0, h + 1'b1, '0, '1);

    // Random chains and noise
    while (issued < 500) begin
      if ($urandom_range(0, 9) < 7)
        chain_burst();
      else
        noise_burst();
    end

    // Fill the table in chains of 32 until allocation reports full
    settle();
    full_mark = n_full;
    guard = 0;
    while (n_full < full_mark + 3 && guard < 40) begin
      steady = ($urandom_range(0, 1) == 0);
      fh = free_head;
      hm = fresh_mark;
      prev = END_MARK;
      repeat (32) begin
        s = guess_grant(fh, hm);
        post(MODE_ALLOC, PTR_W'($urandom_range(0, 32'hFFFF_FFFE)), prev, '0, '0, '0);
        if (s != END_MARK)
          prev = s;
      end
      if (prev != END_MARK)
        heads.push_back(prev);
      settle();
      guard++;
    end
    // release one chain, take it back and run into full again, then release the rest
    if (heads.size() > 0)
      post(MODE_FREE, '0, '0, heads.pop_front(), '0, '1);
    repeat (34) post(MODE_ALLOC, rand64(), END_MARK, '0, '0, '0);
    settle();
    while (heads.size() > 0)
      post(MODE_FREE, '0, '0, heads.pop_front(), '0, '1);

    while (issued < 1700) begin
      if ($urandom_range(0, 9) < 7)
        chain_burst();
      else
        noise_burst();
    end

    // Drain, then allow for any stray strobe
    settle();
    repeat (32) @(posedge clk);
    $display("Run covered %0d transfers (%0d allocate, %0d read, %0d chain free), %0d results.",
             taken, n_alloc, n_read, n_free, checked);
    $display("Seen: %0d table-full, %0d out-of-range, %0d outside-region answers.",
             n_full, n_range, n_region);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #150_000_000;
    $display("Timeout with %0d results still due.", due_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
